// ----- sv/assert_macros.svh -----
// Assertion macros shared by the layer RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/btl_pkg.sv -----
// Shared types, codes and constants for the binary threshold layer.
// No dependencies.
package btl_pkg;

  localparam int DEF_MAX_INPUTS  = 16;
  localparam int DEF_MAX_OUTPUTS = 16;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 4;
  localparam int ENTRY_W = 16;
  localparam int BITS_W  = 16;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_WR_WEIGHT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_BIAS   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EVAL      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_INPUTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_OUTPUTS = 1'd1;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  // at most BITS_W input rows / output lanes ever take part in an evaluation
  function automatic int lanes_used(input int max_count);
    return (max_count < BITS_W) ? max_count : BITS_W;
  endfunction

  typedef struct packed {
    logic load;       // latch input word for an evaluation
    logic wr_weight;
    logic wr_bias;
    logic rd_en;      // read one row from all column memories
    logic rd_first;   // this read is the bias row
    logic rd_last;    // final row of the evaluation
  } btl_cmd_t;

endpackage

// ----- sv/btl_ctrl.sv -----
// Sequencer for the binary threshold layer: decodes commands, steps the row reads.
// Depends on btl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module btl_ctrl
  import btl_pkg::*;
#(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  localparam int EVAL_ROWS = lanes_used(MAX_INPUTS),
  localparam int ADDR_W    = $clog2(EVAL_ROWS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  logic [ADDR_W-1:0] n_in,
  output logic              busy,
  output btl_cmd_t          cmd,
  output logic [ADDR_W-1:0] rd_row
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [ADDR_W-1:0] BIAS_ROW = ADDR_W'(EVAL_ROWS);

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0] n_in_r, n_in_nxt;
  logic              accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);
  // step 0 fetches the bias row, step k+1 fetches weight row k
  assign rd_row = (step_r == '0) ? BIAS_ROW : step_r - ADDR_W'(1);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    n_in_nxt      = n_in_r;
    cmd           = '0;
    cmd.load      = accept && (func == FUNC_EVAL);
    cmd.wr_weight = accept && (func == FUNC_WR_WEIGHT);
    cmd.wr_bias   = accept && (func == FUNC_WR_BIAS);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
          n_in_nxt  = n_in;
        end
      end
      ST_RUN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (step_r == '0);
        cmd.rd_last  = (step_r == n_in_r);
        if (cmd.rd_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      n_in_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      n_in_r  <= n_in_nxt;
    end
  end

  `ASSERT_CLK(a_last_drains, cmd.rd_last |=> state_r == ST_DRAIN, "last read not followed by drain")
  `ASSERT_CLK(a_first_once, cmd.rd_first |=> !cmd.rd_first, "bias row read twice in a row")
  `ASSERT_NEVER(a_no_cmd_busy, busy && (cmd.load || cmd.wr_weight || cmd.wr_bias), "word taken while busy")

endmodule

// ----- sv/btl_dp.sv -----
// Datapath: per-output column memories (weights plus bias row) and accumulators.
// Depends on btl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module btl_dp
  import btl_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int EVAL_ROWS = lanes_used(MAX_INPUTS),
  localparam int OUT_LANES = lanes_used(MAX_OUTPUTS),
  localparam int ADDR_W    = $clog2(EVAL_ROWS + 1),
  localparam int DEPTH     = EVAL_ROWS + 1,
  localparam int ACC_W     = VALUE_WIDTH + 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  btl_cmd_t                  cmd,
  input  logic [ADDR_W-1:0]         rd_row,
  input  logic [IDX_W-1:0]          row_index,
  input  logic [IDX_W-1:0]          column_index,
  input  logic signed [ENTRY_W-1:0] entry_value,
  input  logic [BITS_W-1:0]         input_bits,
  input  logic [CNT_W-1:0]          active_outputs,
  output logic                      out_valid,
  output logic [BITS_W-1:0]         out_bits
);

  localparam logic [ADDR_W-1:0] BIAS_ROW = ADDR_W'(EVAL_ROWS);

  logic signed [VALUE_WIDTH-1:0] wr_val;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          wr_any;
  logic [BITS_W-1:0]             bits_r;
  logic                          rd_vld_r, first_q_r, last_q_r, use_q_r;
  logic                          out_valid_r;
  logic [BITS_W-1:0]             out_bits_r;
  logic [BITS_W-1:0]             lane_fire;

  assign wr_val  = VALUE_WIDTH'(entry_value);
  assign wr_addr = cmd.wr_bias ? BIAS_ROW : ADDR_W'(row_index);
  assign wr_any  = cmd.wr_bias || (cmd.wr_weight && (int'(row_index) < MAX_INPUTS));

  // input word shifts down one bit per weight row read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bits_r <= input_bits;
    end else if (cmd.rd_en && !cmd.rd_first) begin
      bits_r <= bits_r >> 1;
    end
    if (cmd.rd_en) begin
      first_q_r <= cmd.rd_first;
      last_q_r  <= cmd.rd_last;
      use_q_r   <= bits_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.rd_en;
      out_valid_r <= rd_vld_r && last_q_r;
    end
  end

  for (genvar lane = 0; lane < BITS_W; lane++) begin : g_lane
    if (lane < OUT_LANES) begin : g_live
      logic [VALUE_WIDTH-1:0]  mem [DEPTH];
      logic signed [VALUE_WIDTH-1:0] rdata_r;
      logic signed [ACC_W-1:0] acc_r, acc_nxt, w_ext, term;
      logic                    lane_on;

      always_ff @(posedge clk) begin
        if (wr_any && (column_index == IDX_W'(lane))) begin
          mem[wr_addr] <= wr_val;
        end
        if (cmd.rd_en) begin
          rdata_r <= mem[rd_row];
        end
      end

      // accumulator starts at -bias, so the test is sum - bias > 0
      assign w_ext   = ACC_W'(rdata_r);
      assign term    = first_q_r ? -w_ext : (use_q_r ? w_ext : '0);
      assign acc_nxt = (first_q_r ? '0 : acc_r) + term;
      assign lane_on = (int'(active_outputs) > lane);
      assign lane_fire[lane] = lane_on && (acc_nxt > 0);

      always_ff @(posedge clk) begin
        if (rd_vld_r) begin
          acc_r <= acc_nxt;
        end
      end
    end else begin : g_idle
      assign lane_fire[lane] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && last_q_r) begin
      out_bits_r <= lane_fire;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bits  = out_bits_r;

  `ASSERT_CLK(a_single_strobe, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  `ASSERT_CLK(a_strobe_after_last, out_valid_r |-> $past(rd_vld_r && last_q_r), "strobe without last row")

endmodule

// ----- sv/binary_threshold_layer_unit.sv -----
// Binary threshold layer: a perceptron layer with step activation over binary inputs.
// Depends on btl_pkg, btl_ctrl, btl_dp and assert_macros.svh.
//
// Usage: a word is taken when start is high and busy is low. func 0 writes a weight
// (row_index, column_index), func 1 writes the bias of column_index, func 3 is ignored;
// these give no result. func 2 evaluates input_bits over the bias row and N weight rows,
// N = min(active_inputs, 16, MAX_INPUTS): busy stays high while the rows are read and
// summed, and output_bits shows on out_valid for exactly one cycle right after. The
// column memories return one row (the bias row first, then one weight row per input)
// per cycle to all output accumulators. The result cannot be stalled; out_valid must
// be taken when it is shown. Bias and weights must be written before they are
// evaluated. The user must write configuration only while busy is low and no result
// is pending; the block itself does not enforce this.

module binary_threshold_layer_unit
  import btl_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [IDX_W-1:0]          in_row_index,
  input  logic [IDX_W-1:0]          in_column_index,
  input  logic signed [ENTRY_W-1:0] in_entry_value,
  input  logic [BITS_W-1:0]         in_input_bits,
  output logic                      out_valid,
  output logic [BITS_W-1:0]         out_output_bits,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CNT_W-1:0]          cfg_wdata
);

  localparam int EVAL_ROWS = lanes_used(MAX_INPUTS);
  localparam int ADDR_W    = $clog2(EVAL_ROWS + 1);

  logic [CNT_W-1:0]  active_inputs_r, active_outputs_r;
  logic [ADDR_W-1:0] n_in;
  logic [ADDR_W-1:0] rd_row;
  btl_cmd_t          cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_inputs_r  <= CNT_RESET;
      active_outputs_r <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_INPUTS:  active_inputs_r  <= cfg_wdata;
        REG_ACTIVE_OUTPUTS: active_outputs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // rows beyond what the memories hold are never summed
  assign n_in = (int'(active_inputs_r) > EVAL_ROWS) ? ADDR_W'(EVAL_ROWS)
                                                    : ADDR_W'(active_inputs_r);

  btl_ctrl #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func   (in_func),
    .n_in   (n_in),
    .busy   (busy),
    .cmd    (cmd),
    .rd_row (rd_row)
  );

  btl_dp #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_row         (rd_row),
    .row_index      (in_row_index),
    .column_index   (in_column_index),
    .entry_value    (in_entry_value),
    .input_bits     (in_input_bits),
    .active_outputs (active_outputs_r),
    .out_valid      (out_valid),
    .out_bits       (out_output_bits)
  );

endmodule
